// ===== src/irn_pkg.sv =====
// Shared constants, types and helpers for the nearest-neighbor image rotator.
package irn_pkg;

  // Image store geometry
  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int FRAC_BITS = 14;
  localparam int ROW_AW    = $clog2(MAX_ROWS);
  localparam int COL_AW    = $clog2(MAX_COLS);
  localparam int STORE_AW  = ROW_AW + COL_AW;

  // Field and register widths
  localparam int DIM_W     = 9;            // src_rows, src_cols, row, col
  localparam int CS_W      = 16;           // cos_q14, sin_q14
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CH_W      = 8;
  localparam int DEST_W    = 10;           // output size, saturates at 1023
  localparam int DEST_MAX  = 1023;
  localparam int RES_MAX   = 511;

  // Geometry datapath widths
  localparam int GPROD_W   = DIM_W + CS_W;            // corner product
  localparam int GEO_W     = GPROD_W + 1;             // corner sum, bbox min/max
  localparam int GDIF_W    = GEO_W + 1;               // bbox extent
  localparam int GCEIL_W   = GDIF_W - FRAC_BITS;      // extent in pixels

  // Fetch datapath widths
  localparam int YR_W      = GEO_W + 1;               // output coord plus bbox min
  localparam int PM_W      = YR_W + CS_W;             // one mapping product
  localparam int FP_W      = PM_W + 2;                // sum of two products plus round
  localparam int SRC_W     = FP_W - 2 * FRAC_BITS;    // mapped source coordinate

  localparam longint GEO_ROUND = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam longint MAP_ROUND = (64'sd1 <<< (2 * FRAC_BITS)) - 64'sd1;

  // Number of geometry recompute stages run after a register write
  localparam int GEOM_STAGES = 3;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN      = 2'd3;

  localparam logic [CH_W-1:0] WHITE = 8'd255;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch request word
    logic mul;       // mapping products, store write for loads
    logic sum;       // combine products and round up
    logic rd;        // bounds check and store read
    logic out_load;  // fill the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_load;
    logic out_free;
  } sts_t;

  // Clamp a size register to 1..max_dim
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > max_dim) r = max_dim;
    return r;
  endfunction

endpackage

// ===== src/irn_if.sv =====
// Request and response channel interfaces of the image rotator.
interface irn_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [irn_pkg::DIM_W-1:0]    row;
  logic [irn_pkg::DIM_W-1:0]    col;
  logic [irn_pkg::CH_W-1:0]     in_red;
  logic [irn_pkg::CH_W-1:0]     in_green;
  logic [irn_pkg::CH_W-1:0]     in_blue;
  logic [irn_pkg::CH_W-1:0]     in_alpha;

  modport source (output valid, req_type, row, col, in_red, in_green, in_blue, in_alpha,
                  input ready);
  modport sink   (input valid, req_type, row, col, in_red, in_green, in_blue, in_alpha,
                  output ready);
  modport mon    (input valid, ready, req_type, row, col, in_red, in_green, in_blue,
                  in_alpha);
endinterface

interface irn_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [irn_pkg::CH_W-1:0]     out_red;
  logic [irn_pkg::CH_W-1:0]     out_green;
  logic [irn_pkg::CH_W-1:0]     out_blue;
  logic [irn_pkg::CH_W-1:0]     out_alpha;
  logic                         from_source;
  logic [irn_pkg::DIM_W-1:0]    result_rows;
  logic [irn_pkg::DIM_W-1:0]    result_cols;
  logic                         coord_error;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, from_source,
                  result_rows, result_cols, coord_error, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, from_source,
                  result_rows, result_cols, coord_error, output ready);
  modport mon    (input valid, ready, out_red, out_green, out_blue, out_alpha, from_source,
                  result_rows, result_cols, coord_error);
endinterface

// ===== src/irn_ctrl.sv =====
// Sequencing state machine of the image rotator.
module irn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  irn_pkg::sts_t sts_i,
  output irn_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_GEOM = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam int GCNT_W = $clog2(irn_pkg::GEOM_STAGES);
  localparam logic [GCNT_W-1:0] GCNT_LAST = GCNT_W'(irn_pkg::GEOM_STAGES - 1);

  logic [2:0]        state_q, state_d;
  logic [GCNT_W-1:0] gcnt_q, gcnt_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    gcnt_d      = gcnt_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_GEOM: begin
        if (cfg_we_i) begin
          gcnt_d = '0;
        end else if (gcnt_q == GCNT_LAST) begin
          state_d = ST_IDLE;
        end else begin
          gcnt_d = gcnt_q + GCNT_W'(1);
        end
      end
      ST_IDLE: begin
        req_ready_o = !cfg_we_i;
        if (cfg_we_i) begin
          gcnt_d  = '0;
          state_d = ST_GEOM;
        end else if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.is_load ? ST_FIN : ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_GEOM;
        gcnt_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_GEOM;
      gcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      gcnt_q  <= gcnt_d;
    end
  end

endmodule

// ===== src/irn_dp.sv =====
// Datapath of the image rotator: registers, geometry, inverse mapping, pixel store.
module irn_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  irn_pkg::cmd_t                       cmd_i,
  output irn_pkg::sts_t                       sts_o,
  input  logic                                cfg_we_i,
  input  logic [irn_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [irn_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                req_type_i,
  input  logic [irn_pkg::DIM_W-1:0]           row_i,
  input  logic [irn_pkg::DIM_W-1:0]           col_i,
  input  irn_pkg::pixel_t                     pix_i,
  input  logic                                rsp_ready_i,
  output logic                                rsp_valid_o,
  output irn_pkg::pixel_t                     rsp_pix_o,
  output logic                                from_source_o,
  output logic [irn_pkg::DIM_W-1:0]           result_rows_o,
  output logic [irn_pkg::DIM_W-1:0]           result_cols_o,
  output logic                                coord_error_o
);

  localparam int DIM_W  = irn_pkg::DIM_W;
  localparam int CS_W   = irn_pkg::CS_W;
  localparam int GEO_W  = irn_pkg::GEO_W;
  localparam int GDIF_W = irn_pkg::GDIF_W;
  localparam int YR_W   = irn_pkg::YR_W;
  localparam int PM_W   = irn_pkg::PM_W;
  localparam int FP_W   = irn_pkg::FP_W;
  localparam int SRC_W  = irn_pkg::SRC_W;
  localparam int FB     = irn_pkg::FRAC_BITS;
  localparam logic [DIM_W-1:0] MAXR = DIM_W'(irn_pkg::MAX_ROWS);
  localparam logic [DIM_W-1:0] MAXC = DIM_W'(irn_pkg::MAX_COLS);

  function automatic logic signed [GEO_W-1:0] min4(input logic signed [GEO_W-1:0] a,
                                                   input logic signed [GEO_W-1:0] b,
                                                   input logic signed [GEO_W-1:0] c,
                                                   input logic signed [GEO_W-1:0] d);
    logic signed [GEO_W-1:0] m0, m1;
    m0 = (a < b) ? a : b;
    m1 = (c < d) ? c : d;
    return (m0 < m1) ? m0 : m1;
  endfunction

  function automatic logic signed [GEO_W-1:0] max4(input logic signed [GEO_W-1:0] a,
                                                   input logic signed [GEO_W-1:0] b,
                                                   input logic signed [GEO_W-1:0] c,
                                                   input logic signed [GEO_W-1:0] d);
    logic signed [GEO_W-1:0] m0, m1;
    m0 = (a > b) ? a : b;
    m1 = (c > d) ? c : d;
    return (m0 > m1) ? m0 : m1;
  endfunction

  // Configuration registers
  logic [DIM_W-1:0]       src_rows_q, src_cols_q;
  logic signed [CS_W-1:0] cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rows_q <= DIM_W'(1);
      src_cols_q <= DIM_W'(1);
      cos_q      <= CS_W'(1 << FB);
      sin_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        irn_pkg::CFG_SRC_ROWS: src_rows_q <= cfg_data_i[DIM_W-1:0];
        irn_pkg::CFG_SRC_COLS: src_cols_q <= cfg_data_i[DIM_W-1:0];
        irn_pkg::CFG_COS:      cos_q      <= cfg_data_i;
        irn_pkg::CFG_SIN:      sin_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]   eff_rows, eff_cols;
  logic [DIM_W-2:0]   rmax, cmax;
  assign eff_rows = irn_pkg::eff_dim(src_rows_q, MAXR);
  assign eff_cols = irn_pkg::eff_dim(src_cols_q, MAXC);
  assign rmax     = (DIM_W-1)'(eff_rows - DIM_W'(1));
  assign cmax     = (DIM_W-1)'(eff_cols - DIM_W'(1));

  // Geometry stage 1: far-corner products
  logic signed [irn_pkg::GPROD_W-1:0] rc_q, cs_q, cc_q, rs_q;
  always_ff @(posedge clk_i) begin
    rc_q <= $signed({1'b0, rmax}) * cos_q;
    cs_q <= $signed({1'b0, cmax}) * sin_q;
    cc_q <= $signed({1'b0, cmax}) * cos_q;
    rs_q <= $signed({1'b0, rmax}) * sin_q;
  end

  // Geometry stage 2: bounding box over the four corners
  logic signed [GEO_W-1:0] nr1, nr2, nr3, nc1, nc2, nc3;
  logic signed [GEO_W-1:0] rlo_q, rhi_q, clo_q, chi_q;
  assign nr1 = GEO_W'(rc_q);
  assign nr2 = GEO_W'(cs_q);
  assign nr3 = GEO_W'(rc_q) + GEO_W'(cs_q);
  assign nc1 = GEO_W'(cc_q);
  assign nc2 = -GEO_W'(rs_q);
  assign nc3 = GEO_W'(cc_q) - GEO_W'(rs_q);

  always_ff @(posedge clk_i) begin
    rlo_q <= min4('0, nr1, nr2, nr3);
    rhi_q <= max4('0, nr1, nr2, nr3);
    clo_q <= min4('0, nc1, nc2, nc3);
    chi_q <= max4('0, nc1, nc2, nc3);
  end

  // Geometry stage 3: bbox minimum and output size, rounded up and saturated
  logic [GDIF_W-1:0]             rdif, cdif;
  logic [irn_pkg::GCEIL_W-1:0]   rext, cext;
  logic [irn_pkg::DEST_W-1:0]    dest_rows_d, dest_cols_d, dest_rows_q, dest_cols_q;
  logic signed [GEO_W-1:0]       row_min_q, col_min_q;

  assign rdif = GDIF_W'(GDIF_W'(rhi_q) - GDIF_W'(rlo_q) + GDIF_W'(irn_pkg::GEO_ROUND));
  assign cdif = GDIF_W'(GDIF_W'(chi_q) - GDIF_W'(clo_q) + GDIF_W'(irn_pkg::GEO_ROUND));
  assign rext = rdif[GDIF_W-1:FB];
  assign cext = cdif[GDIF_W-1:FB];
  assign dest_rows_d = (rext > irn_pkg::GCEIL_W'(irn_pkg::DEST_MAX)) ?
                       irn_pkg::DEST_W'(irn_pkg::DEST_MAX) : irn_pkg::DEST_W'(rext);
  assign dest_cols_d = (cext > irn_pkg::GCEIL_W'(irn_pkg::DEST_MAX)) ?
                       irn_pkg::DEST_W'(irn_pkg::DEST_MAX) : irn_pkg::DEST_W'(cext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_min_q   <= '0;
      col_min_q   <= '0;
      dest_rows_q <= '0;
      dest_cols_q <= '0;
    end else begin
      row_min_q   <= rlo_q;
      col_min_q   <= clo_q;
      dest_rows_q <= dest_rows_d;
      dest_cols_q <= dest_cols_d;
    end
  end

  // Request capture: offset coordinates, range check, load word
  logic                              type_q, err_q;
  logic signed [YR_W-1:0]            yr_q, yc_q;
  logic [irn_pkg::STORE_AW-1:0]      waddr_q;
  irn_pkg::pixel_t                   wpix_q;
  logic                              err_d;
  logic signed [YR_W-1:0]            row_fx, col_fx;

  assign row_fx = $signed({(YR_W-DIM_W-FB)'(0), row_i, FB'(0)});
  assign col_fx = $signed({(YR_W-DIM_W-FB)'(0), col_i, FB'(0)});

  always_comb begin
    if (req_type_i == irn_pkg::REQ_LOAD) begin
      err_d = (row_i >= eff_rows) || (col_i >= eff_cols);
    end else begin
      err_d = (irn_pkg::DEST_W'(row_i) >= dest_rows_q) ||
              (irn_pkg::DEST_W'(col_i) >= dest_cols_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      type_q  <= req_type_i;
      err_q   <= err_d;
      yr_q    <= row_fx + YR_W'(row_min_q);
      yc_q    <= col_fx + YR_W'(col_min_q);
      waddr_q <= {row_i[irn_pkg::ROW_AW-1:0], col_i[irn_pkg::COL_AW-1:0]};
      wpix_q  <= pix_i;
    end
  end

  assign sts_o.is_load = (type_q == irn_pkg::REQ_LOAD);

  // Mapping products
  logic signed [PM_W-1:0] p_rc_q, p_cs_q, p_rs_q, p_cc_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_rc_q <= yr_q * cos_q;
      p_cs_q <= yc_q * sin_q;
      p_rs_q <= yr_q * sin_q;
      p_cc_q <= yc_q * cos_q;
    end
  end

  // Combine and round up to the source coordinate
  logic signed [FP_W-1:0]  vr, vc;
  logic signed [SRC_W-1:0] sr_q, sc_q;
  assign vr = FP_W'(p_rc_q) - FP_W'(p_cs_q) + FP_W'(irn_pkg::MAP_ROUND);
  assign vc = FP_W'(p_rs_q) + FP_W'(p_cc_q) + FP_W'(irn_pkg::MAP_ROUND);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      sr_q <= SRC_W'(vr >>> (2 * FB));
      sc_q <= SRC_W'(vc >>> (2 * FB));
    end
  end

  // Source bounds check
  logic in_src;
  assign in_src = !sr_q[SRC_W-1] && !sc_q[SRC_W-1] &&
                  (sr_q[SRC_W-2:0] < (SRC_W-1)'(eff_rows)) &&
                  (sc_q[SRC_W-2:0] < (SRC_W-1)'(eff_cols));

  // Pixel store: written by loads, read by fetches
  logic [31:0]                   store_mem [irn_pkg::MAX_ROWS * irn_pkg::MAX_COLS];
  logic [irn_pkg::STORE_AW-1:0]  raddr;
  irn_pkg::pixel_t               rdata_q;
  logic                          from_q;

  assign raddr = {sr_q[irn_pkg::ROW_AW-1:0], sc_q[irn_pkg::COL_AW-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul && sts_o.is_load && !err_q) begin
      store_mem[waddr_q] <= wpix_q;
    end
    if (cmd_i.rd) begin
      rdata_q <= store_mem[raddr];
      from_q  <= in_src && !err_q;
    end
  end

  // Output register
  logic            take_src;
  irn_pkg::pixel_t white;
  assign take_src  = !sts_o.is_load && from_q;
  assign white     = {4{irn_pkg::WHITE}};
  assign sts_o.out_free = !rsp_valid_o || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      rsp_valid_o <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_pix_o     <= take_src ? rdata_q : white;
      from_source_o <= take_src;
      coord_error_o <= err_q;
      result_rows_o <= (dest_rows_q > irn_pkg::DEST_W'(irn_pkg::RES_MAX)) ?
                       DIM_W'(irn_pkg::RES_MAX) : dest_rows_q[DIM_W-1:0];
      result_cols_o <= (dest_cols_q > irn_pkg::DEST_W'(irn_pkg::RES_MAX)) ?
                       DIM_W'(irn_pkg::RES_MAX) : dest_cols_q[DIM_W-1:0];
    end
  end

endmodule

// ===== src/image_rotate_nearest_core.sv =====
// Top level of the nearest-neighbor RGBA image rotator.
//
// Usage: set src_rows, src_cols, cos_q14 and sin_q14 through the write port
// (cfg_we_i, cfg_idx_i, cfg_data_i) while the block is idle. Each write starts a
// geometry recompute (bounding box and output size), during which req_i.ready is
// low. Load words on req_i write one pixel into the 256x256 store; fetch words
// name an output pixel, which is mapped back to the source and read from the
// store, or filled with opaque white. Every word gives one word on rsp_o,
// carrying the output image size and an out-of-range flag. A load passes
// through capture, store write and the output register; a fetch passes through
// capture, products, round-up, store read and the output register. One word is
// in flight at a time: a new word is taken only once the last one has reached
// the output register, under control of the sequencing state machine.
// The response sits in an output register: the next request is accepted while
// it waits; a word that finishes while rsp_o is stalled holds until it drains.
// Reset clears the registers to their defaults and runs the geometry recompute;
// the pixel store is not cleared and must be loaded before it is fetched.
module image_rotate_nearest_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irn_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [irn_pkg::CFG_W-1:0]        cfg_data_i,
  irn_req_if.sink                          req_i,
  irn_rsp_if.source                        rsp_o
);

  irn_pkg::cmd_t   cmd;
  irn_pkg::sts_t   sts;
  irn_pkg::pixel_t in_pix, out_pix;
  logic            req_ready;

  assign req_i.ready = req_ready;

  assign in_pix.red   = req_i.in_red;
  assign in_pix.green = req_i.in_green;
  assign in_pix.blue  = req_i.in_blue;
  assign in_pix.alpha = req_i.in_alpha;

  assign rsp_o.out_red   = out_pix.red;
  assign rsp_o.out_green = out_pix.green;
  assign rsp_o.out_blue  = out_pix.blue;
  assign rsp_o.out_alpha = out_pix.alpha;

  irn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  irn_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_i.req_type),
    .row_i         (req_i.row),
    .col_i         (req_i.col),
    .pix_i         (in_pix),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_pix_o     (out_pix),
    .from_source_o (rsp_o.from_source),
    .result_rows_o (rsp_o.result_rows),
    .result_cols_o (rsp_o.result_cols),
    .coord_error_o (rsp_o.coord_error)
  );

endmodule

// ===== src/irn_chk.sv =====
// Port-level checker for the image rotator, bound to the top level.
module irn_chk (
  input logic        clk_i,
  input logic        rst_ni,
  irn_req_if.sink    req_i,
  irn_rsp_if.source  rsp_o
);

  // A stalled response word stays valid
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid)
    else $error("response dropped while stalled");

  // A stalled response word keeps its pixel
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> $stable(rsp_o.out_red) && $stable(rsp_o.out_green) &&
      $stable(rsp_o.out_blue) && $stable(rsp_o.out_alpha) && $stable(rsp_o.from_source))
    else $error("response changed while stalled");

  // One word in flight: no request taken right after another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted back to back");

  // An out-of-range word never returns a store pixel
  a_err_not_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.from_source && rsp_o.coord_error))
    else $error("store pixel returned with coordinate error");

  // Fill words are opaque white
  a_fill_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.from_source |-> (rsp_o.out_red == irn_pkg::WHITE) &&
      (rsp_o.out_green == irn_pkg::WHITE) && (rsp_o.out_blue == irn_pkg::WHITE) &&
      (rsp_o.out_alpha == irn_pkg::WHITE))
    else $error("fill pixel is not white");

endmodule

bind image_rotate_nearest_core irn_chk u_irn_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);
